// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tone generator RTL.
// Define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== hdl/ttg_pkg.sv =====
// Shared types and constants of the table tone generator.
// No dependencies.
package ttg_pkg;

  localparam int HALF_PERIOD_BITS_DEF = 16;
  localparam int TABLE_DEPTH_DEF      = 255;
  localparam int CFG_INDEX_BITS       = 2;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_SELECT = 2'd1;

  // wave select codes
  localparam logic [1:0] WAVE_OFF    = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_SINE   = 2'd2;
  localparam logic [1:0] WAVE_SQUARE = 2'd3;

  localparam logic [7:0] LEVEL_MID = 8'd127;

  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_IDX,
    ST_ROM,
    ST_SLEW,
    ST_DONE
  } ttg_state_t;

endpackage

// ===== hdl/ttg_if.sv =====
// Stream and configuration channel interfaces of the tone generator.
// No dependencies beyond ttg_pkg.
interface ttg_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink (input valid, input tick, output ready);
endinterface

interface ttg_level_if;
  logic       valid;
  logic       ready;
  logic [7:0] dac_value;
  logic       dac_write;
  modport source (output valid, output dac_value, output dac_write, input ready);
  modport sink (input valid, input dac_value, input dac_write, output ready);
endinterface

interface ttg_cfg_if import ttg_pkg::*; #(
  parameter int DATA_BITS = 16
);
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [DATA_BITS-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ttg_divider.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module ttg_divider #(
  parameter int NUM_BITS = 25,
  parameter int DEN_BITS = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                done,
  input  logic [NUM_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0] divisor,
  output logic [NUM_BITS-1:0] quotient,
  output logic [DEN_BITS-1:0] remainder
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] num;
  logic [DEN_BITS-1:0] den;
  logic [DEN_BITS-1:0] rem;
  logic [NUM_BITS-1:0] quo;
  logic [CNT_BITS-1:0] cnt;
  logic                running;

  logic [DEN_BITS:0]   trial;
  logic                fits;
  logic [DEN_BITS:0]   diff;

  always_comb begin
    trial = {rem, num[NUM_BITS-1]};
    fits  = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= CNT_BITS'(NUM_BITS);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
      den <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (running) begin
      num <= {num[NUM_BITS-2:0], 1'b0};
      quo <= {quo[NUM_BITS-2:0], fits};
      rem <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== hdl/table_tone_generator.sv =====
// Handles tick low, silence and playing a wave. One tick at a time: a new tick
// is accepted only after the level of the last one is registered for tone_out.
// The shared bit-serial divider runs twice per playing tick.
// Reset (rst, synchronous): phase 0, level 127, registers 0, no word pending.
module table_tone_generator import ttg_pkg::*; #(
  parameter int HALF_PERIOD_BITS = HALF_PERIOD_BITS_DEF,
  parameter int TABLE_DEPTH      = TABLE_DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ttg_tick_if.sink   tone_in,
  ttg_level_if.source tone_out,
  ttg_cfg_if.sink    cfg
);

`include "assert_macros.svh"

  localparam int PH_BITS  = HALF_PERIOD_BITS + 1;
  localparam int IDX_BITS = $clog2(TABLE_DEPTH);
  localparam int NUM_BITS = PH_BITS + $clog2(TABLE_DEPTH + 1);
  localparam int CMP_BITS = ((IDX_BITS > 8) ? IDX_BITS : 8) + 1;

  // sine level for table entry i, quadrant folded, Taylor series in Q30
  function automatic logic [7:0] sine_level(longint unsigned i);
    longint unsigned q, quad, r, y, y2, term, pos, neg, m, total;
    q    = 4 * i;
    quad = q / TABLE_DEPTH;
    r    = q % TABLE_DEPTH;
    if (quad[0]) r = TABLE_DEPTH - r;
    y    = (HALF_PI_Q30 * r) / TABLE_DEPTH;
    y2   = (y * y) >> 30;
    pos  = y;
    term = ((y * y2) >> 30) / 6;
    neg  = term;
    term = ((term * y2) >> 30) / 20;
    pos  = pos + term;
    term = ((term * y2) >> 30) / 42;
    neg  = neg + term;
    term = ((term * y2) >> 30) / 72;
    pos  = pos + term;
    term = ((term * y2) >> 30) / 110;
    neg  = neg + term;
    term = ((term * y2) >> 30) / 156;
    pos  = pos + term;
    term = ((term * y2) >> 30) / 210;
    neg  = neg + term;
    if (neg >= pos) m = 0;
    else begin
      m = pos - neg;
      if (m > Q30_ONE) m = Q30_ONE;
    end
    total = 256 * Q30_ONE;
    if (quad >= 2) total = total - 255 * m;
    else           total = total + 255 * m;
    total = total >> 31;
    return (total > 255) ? 8'hff : total[7:0];
  endfunction

  logic [7:0] sine_rom [TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_rom
    localparam logic [7:0] SINE_ENTRY = sine_level(longint'(g));
    assign sine_rom[g] = SINE_ENTRY;
  end

  ttg_state_t state, state_next;

  logic [HALF_PERIOD_BITS-1:0] half_period;
  logic [1:0]                  wave_select;
  logic [PH_BITS-1:0]          phase_count;
  logic [7:0]                  last_level;
  logic [IDX_BITS-1:0]         idx;
  logic [7:0]                  rom_q;
  logic [7:0]                  target;
  logic                        wr;
  logic                        out_valid;
  logic [7:0]                  out_level;
  logic                        out_write;

  logic                in_acc;
  logic                active;
  logic                out_free;
  logic                div_start;
  logic                div_done;
  logic [NUM_BITS-1:0] div_num;
  logic [NUM_BITS-1:0] div_quo;
  logic [PH_BITS-1:0]  div_rem;
  logic [PH_BITS-1:0]  span;
  logic [IDX_BITS-1:0] quo_idx;
  logic [CMP_BITS-1:0] idx_w;
  logic [7:0]          wave_level;
  logic [7:0]          slew_level;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= '0;
      wave_select <= WAVE_OFF;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_PERIOD: half_period <= HALF_PERIOD_BITS'(cfg.data);
        REG_WAVE_SELECT: wave_select <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  assign active   = (wave_select != WAVE_OFF) && (half_period != '0);
  assign span     = {half_period, 1'b0};
  assign out_free = !out_valid || tone_out.ready;
  assign in_acc   = tone_in.valid && tone_in.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (tone_in.tick && active) state_next = ST_MOD;
          else if (tone_in.tick)      state_next = ST_SLEW;
          else                        state_next = ST_DONE;
        end
      end
      ST_MOD:  if (div_done) state_next = ST_MUL;
      ST_MUL:  state_next = ST_IDX;
      ST_IDX:  if (div_done) state_next = ST_ROM;
      ST_ROM:  state_next = ST_SLEW;
      ST_SLEW: state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    tone_in.ready = (state == ST_IDLE) && !rst;
    div_start     = 1'b0;
    div_num       = NUM_BITS'(phase_count) + NUM_BITS'(1);
    case (state)
      ST_IDLE: div_start = in_acc && tone_in.tick && active;
      ST_MUL: begin
        div_start = 1'b1;
        div_num   = NUM_BITS'(phase_count) * NUM_BITS'(TABLE_DEPTH);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  ttg_divider #(
    .NUM_BITS (NUM_BITS),
    .DEN_BITS (PH_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .done      (div_done),
    .dividend  (div_num),
    .divisor   (span),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    quo_idx = (div_quo >= NUM_BITS'(TABLE_DEPTH)) ? IDX_BITS'(TABLE_DEPTH - 1)
                                                  : div_quo[IDX_BITS-1:0];
    idx_w = CMP_BITS'(idx);
    case (wave_select)
      WAVE_SAW:  wave_level = 8'(idx);
      WAVE_SINE: wave_level = rom_q;
      default:   wave_level = (idx_w > CMP_BITS'(127)) ? 8'hff : 8'h00;
    endcase
    // halve the gap, truncated toward zero
    if (target > last_level)
      slew_level = last_level + ((target - last_level) >> 1);
    else
      slew_level = last_level - ((last_level - target) >> 1);
  end

  // quotient holds after the divide, so the ROM word is ready with idx
  always_ff @(posedge clk) begin
    rom_q <= sine_rom[quo_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count <= '0;
      last_level  <= LEVEL_MID;
      out_valid   <= 1'b0;
    end else begin
      if (state == ST_MOD && div_done) phase_count <= div_rem;
      if (state == ST_SLEW) last_level <= slew_level;
      if (state == ST_DONE && out_free) out_valid <= 1'b1;
      else if (tone_out.ready)          out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      target <= LEVEL_MID;
      wr     <= 1'b0;
    end
    if (state == ST_IDX && div_done) idx <= quo_idx;
    if (state == ST_ROM) target <= wave_level;
    if (state == ST_SLEW) wr <= (target != last_level);
    if (state == ST_DONE && out_free) begin
      out_level <= last_level;
      out_write <= wr;
    end
  end

  assign tone_out.valid     = out_valid;
  assign tone_out.dac_value = out_level;
  assign tone_out.dac_write = out_write;

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_acc, state != ST_IDLE)
  `ASSERT_IMPLIES(a_div_done_owned, clk, rst, div_done,
    state == ST_MOD || state == ST_IDX)
  `ASSERT_IMPLIES(a_idx_in_table, clk, rst, state == ST_ROM,
    CMP_BITS'(idx) < CMP_BITS'(TABLE_DEPTH))

endmodule
